FILE: rtl/vwcp_pkg.sv
// ----------------------------------------------------------------------------
// vwcp_pkg
// Shared types and constants of the variable width code packer.
// ----------------------------------------------------------------------------
package vwcp_pkg;

	localparam int WORD_BITS  = 16;
	localparam int WIDTH_BITS = 5;
	localparam int FILL_BITS  = 4;
	localparam int JOIN_BITS  = 2 * WORD_BITS - 1;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(9);
	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(WORD_BITS);

	typedef enum logic {
		MODE_APPEND = 1'b0,
		MODE_FLUSH  = 1'b1
	} mode_t;

	// One input beat as it travels from the input register to the packer.
	typedef struct packed {
		mode_t                 mode;
		logic [WORD_BITS-1:0] code;
	} item_t;

endpackage

FILE: rtl/vwcp_in_reg.sv
// ----------------------------------------------------------------------------
// vwcp_in_reg
// Input register: holds one accepted beat until the packer takes it.
// ----------------------------------------------------------------------------
module vwcp_in_reg
	import vwcp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  item_valid,
	input  logic  item_take,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	// A new beat may enter when the register is empty or is drained this cycle.
	assign in_ready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: rtl/vwcp_pack.sv
// ----------------------------------------------------------------------------
// vwcp_pack
// Bit accumulator, shift-and-or packing logic and the output word register.
// ----------------------------------------------------------------------------
module vwcp_pack
	import vwcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [WIDTH_BITS-1:0] code_width,
	input  logic                  item_valid,
	output logic                  item_take,
	input  item_t                 item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  packed_word
);

	logic [WORD_BITS-1:0]  acc_q;
	logic [FILL_BITS-1:0]  fill_q;
	logic                  out_valid_q;
	logic [WORD_BITS-1:0]  word_q;

	logic                  advance;
	logic                  do_item;
	logic [WIDTH_BITS-1:0] w_sat;
	logic [WORD_BITS:0]    mask_wide;
	logic [WORD_BITS-1:0]  bits;
	logic [JOIN_BITS-1:0]  joined;
	logic [WIDTH_BITS-1:0] total;
	logic [FILL_BITS-1:0]  rest;
	logic [WORD_BITS-1:0]  rest_mask;
	logic [WIDTH_BITS-1:0] flush_shift;

	logic                  emit;
	logic [WORD_BITS-1:0]  emit_word;
	logic [WORD_BITS-1:0]  acc_d;
	logic [FILL_BITS-1:0]  fill_d;

	// The packer moves whenever the output register is free or being read.
	assign advance   = !out_valid_q || out_ready;
	assign item_take = advance;
	assign do_item   = advance && item_valid;

	always_comb begin
		w_sat       = (code_width > WIDTH_MAX) ? WIDTH_MAX : code_width;
		mask_wide   = ((WORD_BITS+1)'(1) << w_sat) - (WORD_BITS+1)'(1);
		bits        = item.code & mask_wide[WORD_BITS-1:0];
		joined      = ({{(JOIN_BITS-WORD_BITS){1'b0}}, acc_q} << w_sat)
		            | {{(JOIN_BITS-WORD_BITS){1'b0}}, bits};
		total       = {1'b0, fill_q} + w_sat;
		rest        = total[FILL_BITS-1:0];
		rest_mask   = (WORD_BITS'(1) << rest) - WORD_BITS'(1);
		flush_shift = WIDTH_BITS'(WORD_BITS) - {1'b0, fill_q};

		emit      = 1'b0;
		emit_word = '0;
		acc_d     = acc_q;
		fill_d    = fill_q;
		case (item.mode)
			MODE_FLUSH: begin
				if (fill_q != '0) begin
					emit      = 1'b1;
					emit_word = acc_q << flush_shift;
					acc_d     = '0;
					fill_d    = '0;
				end
			end
			MODE_APPEND: begin
				if (w_sat != '0) begin
					if (total[WIDTH_BITS-1]) begin
						// A full word is done; the spare low bits stay pending.
						emit      = 1'b1;
						emit_word = WORD_BITS'(joined >> rest);
						acc_d     = joined[WORD_BITS-1:0] & rest_mask;
						fill_d    = rest;
					end else begin
						acc_d  = joined[WORD_BITS-1:0];
						fill_d = total[FILL_BITS-1:0];
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_item) begin
				acc_q  <= acc_d;
				fill_q <= fill_d;
			end
			if (advance) begin
				out_valid_q <= do_item && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_item && emit) begin
			word_q <= emit_word;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_word = word_q;

	// Pending bits always sit below the fill count.
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> fill_q) == '0)
		else $error("accumulator holds bits above the fill count");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(do_item && item.mode == MODE_FLUSH) |=> (fill_q == '0 && acc_q == '0))
		else $error("flush left pending bits");

	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(do_item && item.mode == MODE_FLUSH && fill_q == '0) |=> !out_valid_q)
		else $error("empty flush produced a word");

	a_short_append: assert property (@(posedge clk) disable iff (!arst_n)
		(do_item && item.mode == MODE_APPEND && !total[WIDTH_BITS-1])
		|=> (!out_valid_q && fill_q == $past(total[FILL_BITS-1:0])))
		else $error("append below a full word misbehaved");

endmodule

FILE: rtl/variable_width_code_packer.sv
// ----------------------------------------------------------------------------
// variable_width_code_packer
// Packs 1 to 16 bit codes msb first into 16-bit words, with zero-padded flush.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_ready is high. The beat
// that completes a word passes the input register, then the output word
// register, with the accumulator updated by a combinational shift-and-or
// between them. Ready drops only while the output word waits.
// The code width register resets to 9; widths above 16 act as 16 and a width
// of zero appends nothing. Write it only while no beats are in flight.
module variable_width_code_packer
	import vwcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIDTH_BITS-1:0] code_width,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [WORD_BITS-1:0]  code_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  packed_word
);

	logic [WIDTH_BITS-1:0] width_q;
	item_t                 in_item;
	item_t                 item;
	logic                  item_valid;
	logic                  item_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= code_width;
		end
	end

	assign in_item.mode = mode_t'(mode);
	assign in_item.code = code_value;

	vwcp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	vwcp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_width  (width_q),
		.item_valid  (item_valid),
		.item_take   (item_take),
		.item        (item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_word (packed_word)
	);

endmodule

FILE: verif/variable_width_code_packer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_width_code_packer_tb
// Self-checking bench for the msb-first code packer. Code and flush beats go
// in under random idling on both sides. A scoreboard keeps its own copy of
// the accumulator and the width register. It predicts every packed word and
// compares each output beat with the oldest word it still expects.
// ----------------------------------------------------------------------------
import vwcp_pkg::*;

class word_scoreboard;
	logic [WIDTH_BITS-1:0] width_reg;
	logic [WORD_BITS-1:0]  pending_bits;
	logic [FILL_BITS-1:0]  pending_count;
	logic [WORD_BITS-1:0]  expected_words[$];
	int                    mismatches;

	function new();
		width_reg     = WIDTH_RESET;
		pending_bits  = '0;
		pending_count = '0;
		mismatches    = 0;
	endfunction

	function void set_width(logic [WIDTH_BITS-1:0] w);
		width_reg = w;
	endfunction

	task report(string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Advances the packer state by one accepted input beat.
	function void note_code_beat(mode_t m, logic [WORD_BITS-1:0] code);
		int                    w;
		int                    total;
		logic [JOIN_BITS-1:0]  joined;
		logic [WORD_BITS-1:0]  bits;
		if (m == MODE_FLUSH) begin
			if (pending_count != 0) begin
				expected_words.push_back(WORD_BITS'(pending_bits << (WORD_BITS - pending_count)));
				pending_bits  = '0;
				pending_count = '0;
			end
			return;
		end
		// Widths above a full word act as a full word.
		w = (width_reg > WIDTH_MAX) ? WORD_BITS : int'(width_reg);
		if (w == 0)
			return;
		bits   = code & WORD_BITS'((32'd1 << w) - 1);
		total  = int'(pending_count) + w;
		joined = (JOIN_BITS'(pending_bits) << w) | JOIN_BITS'(bits);
		if (total >= WORD_BITS) begin
			expected_words.push_back(WORD_BITS'(joined >> (total - WORD_BITS)));
			pending_count = FILL_BITS'(total - WORD_BITS);
			pending_bits  = WORD_BITS'(joined & ((JOIN_BITS'(1) << pending_count) - 1));
		end else begin
			pending_bits  = joined[WORD_BITS-1:0];
			pending_count = FILL_BITS'(total);
		end
	endfunction

	task check_packed_word(logic [WORD_BITS-1:0] got);
		logic [WORD_BITS-1:0] want;
		if (expected_words.size() == 0) begin
			report($sformatf("unexpected packed_word %04h", got));
			return;
		end
		want = expected_words.pop_front();
		if (got !== want)
			report($sformatf("packed_word %04h, expected %04h", got, want));
	endtask
endclass

module variable_width_code_packer_tb;

	localparam int LONG_HOLD      = 200;
	localparam int STALL_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASES         = 14;
	localparam int PHASE_BEATS    = 100;
	localparam int HOLD_PHASE     = 2;
	localparam int DRY_PHASE      = 5;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [WIDTH_BITS-1:0] code_width  = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  mode        = MODE_APPEND;
	logic [WORD_BITS-1:0]  code_value  = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [WORD_BITS-1:0]  packed_word;

	bit                    hold_request = 1'b0;
	bit                    quiet_tail   = 1'b0;
	int                    stalled_cycles = 0;
	word_scoreboard        board = new();

	variable_width_code_packer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.code_width  (code_width),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.code_value  (code_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_word (packed_word)
	);

	always #4 clk = ~clk;

	// Output beats are checked before the input beat of the same edge is
	// noted, since a word never leaves in the cycle its last code enters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_packed_word(packed_word);
			if (in_valid && in_ready)
				board.note_code_beat(mode_t'(mode), code_value);
			if (cfg_valid && cfg_ready)
				board.set_width(code_width);
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
				stalled_cycles = 0;
			end else begin
				stalled_cycles++;
				if (stalled_cycles >= STALL_LIMIT) begin
					$display("ERROR at %0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	initial begin : receiver
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task send_beat(input mode_t m, input logic [WORD_BITS-1:0] c);
		in_valid   <= 1'b1;
		mode       <= m;
		code_value <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Waits for every expected word, then lets trailing beats that make no
	// word work their way through the pipeline.
	task drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_width(input logic [WIDTH_BITS-1:0] w);
		drain();
		cfg_valid  <= 1'b1;
		code_width <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int                    phase;
		int                    i;
		int                    gap_pct;
		logic [WIDTH_BITS-1:0] w;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset width of nine: one word plus a two-bit tail, then an empty flush.
		send_beat(MODE_APPEND, 16'hFFFF);
		send_beat(MODE_APPEND, 16'h0000);
		send_beat(MODE_FLUSH,  16'hFFFF);
		send_beat(MODE_FLUSH,  16'h0000);

		write_width(5'd16);
		send_beat(MODE_APPEND, 16'hFFFF);
		send_beat(MODE_APPEND, 16'h0000);
		send_beat(MODE_APPEND, 16'hA5C3);
		send_beat(MODE_FLUSH,  16'h1234);

		// Only the lowest bit counts at width one.
		write_width(5'd1);
		send_beat(MODE_APPEND, 16'hFFFF);
		send_beat(MODE_APPEND, 16'hFFFE);
		send_beat(MODE_APPEND, 16'h0001);
		send_beat(MODE_FLUSH,  16'h0000);

		// Width zero appends nothing, so the flush after it is empty.
		write_width(5'd0);
		send_beat(MODE_APPEND, 16'hFFFF);
		send_beat(MODE_FLUSH,  16'hFFFF);

		// The largest register value saturates to a full word.
		write_width(5'd31);
		send_beat(MODE_APPEND, 16'h8001);
		send_beat(MODE_FLUSH,  16'h0000);

		write_width(5'd15);
		send_beat(MODE_APPEND, 16'h7FFF);
		send_beat(MODE_APPEND, 16'hFFFF);
		send_beat(MODE_FLUSH,  16'h0000);

		for (phase = 0; phase < PHASES; phase++) begin
			if ($urandom_range(0, 7) == 0)
				w = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
			else
				w = 5'($urandom_range(1, 16));
			write_width(w);
			quiet_tail = (phase >= PHASES - 2);
			gap_pct    = (quiet_tail || $urandom_range(0, 2) == 0) ? 0 : 25;
			// The receiver stalls for a long stretch while beats keep coming,
			// so the block fills up and pushes back on the input.
			if (phase == HOLD_PHASE)
				hold_request = 1'b1;
			for (i = 0; i < PHASE_BEATS; i++) begin
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
					pause_sender($urandom_range(1, 13));
				send_beat(($urandom_range(0, 11) == 0) ? MODE_FLUSH : MODE_APPEND,
					WORD_BITS'($urandom));
				if (phase == DRY_PHASE && i == PHASE_BEATS / 2)
					drain();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
